>>> rtl/cpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpq_pkg
// Types and constants shared by the paced transmit queue modules.
// ----------------------------------------------------------------------------
package cpq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W       = (CNT_W > 7) ? CNT_W : 7;

	localparam logic [15:0] HOLD_TIME_RST    = 16'd5;
	localparam logic [15:0] PEN_WIN_RST      = 16'd10;
	localparam logic [7:0]  BASE_MULT_RST    = 8'd20;
	localparam logic [6:0]  BUFFER_LIMIT_RST = 7'd64;

	typedef enum logic [1:0] {
		OP_ARRIVE   = 2'd0,
		OP_FEEDBACK = 2'd1,
		OP_TICK     = 2'd2,
		OP_UNUSED   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_QUEUED   = 3'd0,
		ST_DROPPED  = 3'd1,
		ST_SENT     = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_FEEDBACK = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_HOLD_TIME    = 2'd0,
		REG_PEN_WIN      = 2'd1,
		REG_BASE_MULT    = 2'd2,
		REG_BUFFER_LIMIT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] now;
		logic [15:0] packet_id;
		logic [15:0] packet_duration;
	} cpq_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] sent_id;
		logic [24:0] service_time;
		logic        start_service;
		logic        bottleneck_active;
		logic [6:0]  queue_count;
	} cpq_res_t;

	typedef struct packed {
		logic event_en;
		logic feedback;
	} cpq_pace_ctl_t;

endpackage

>>> rtl/cpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpq_cell
// One queue slot: takes its upstream neighbor on a pop, the new packet on a push.
// ----------------------------------------------------------------------------
module cpq_cell (
	input  logic        clk,
	input  logic        shift_en,
	input  logic        load_en,
	input  logic [15:0] next_id,
	input  logic [15:0] next_dur,
	input  logic [15:0] load_id,
	input  logic [15:0] load_dur,
	output logic [15:0] id,
	output logic [15:0] dur
);

	logic [15:0] id_q;
	logic [15:0] dur_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			id_q  <= next_id;
			dur_q <= next_dur;
		end else if (load_en) begin
			id_q  <= load_id;
			dur_q <= load_dur;
		end
	end

	assign id  = id_q;
	assign dur = dur_q;

endmodule

>>> rtl/cpq_pace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpq_pace
// Bottleneck tracking and service time scaling for the head packet.
// ----------------------------------------------------------------------------
module cpq_pace (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cpq_pkg::cpq_pace_ctl_t ctl,
	input  logic [31:0]           now,
	input  logic [15:0]           hold_time,
	input  logic [15:0]           pen_win,
	input  logic [7:0]            base_multiplier,
	input  logic [15:0]           head_dur,
	output logic                  bottleneck,
	output logic [24:0]           service_time
);
	import cpq_pkg::*;

	logic        in_bn_q;
	logic        doubled_q;
	logic [31:0] window_end_q;

	logic [32:0] end_sum;
	logic [31:0] end_sat;
	logic [32:0] diff;
	logic        begin_bn;
	logic        in_bn_mid;
	logic        dbl_mid;
	logic [31:0] wend_mid;
	logic        bn_n;
	logic        dbl_n;
	logic [23:0] prod;

	always_comb begin
		end_sum  = {1'b0, now} + {17'b0, hold_time};
		end_sat  = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
		diff     = {1'b0, now} - {1'b0, window_end_q};
		begin_bn = ctl.feedback && !in_bn_q;
		in_bn_mid = in_bn_q || begin_bn;
		dbl_mid  = doubled_q ||
			(begin_bn && ($signed(diff) < $signed({17'b0, pen_win})));
		wend_mid = begin_bn ? end_sat : window_end_q;
		if (in_bn_mid && (now >= wend_mid)) begin
			bn_n  = 1'b0;
			dbl_n = 1'b0;
		end else begin
			bn_n  = in_bn_mid;
			dbl_n = dbl_mid;
		end
		prod = head_dur * base_multiplier;
		if (!bn_n) begin
			service_time = {9'b0, head_dur};
		end else if (dbl_n) begin
			service_time = {prod, 1'b0};
		end else begin
			service_time = {1'b0, prod};
		end
	end

	assign bottleneck = bn_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bn_q      <= 1'b0;
			doubled_q    <= 1'b0;
			window_end_q <= '0;
		end else if (ctl.event_en) begin
			in_bn_q      <= bn_n;
			doubled_q    <= dbl_n;
			window_end_q <= wend_mid;
		end
	end

endmodule

>>> rtl/congestion_paced_tx_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// congestion_paced_tx_queue
// Transmit queue with congestion pacing, built as a shifting row of slots.
//
//  channel   handshake               payload
//  request   start / busy            request  (cpq_req_t)
//  result    done strobe, 1 cycle    result   (cpq_res_t)
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// each request is accepted, then executed: in the execute cycle the slot row
// shifts or loads and the pacing multiplier scales the head duration; busy is
// high during execute, the result strobes in the next cycle while a new request
// may be accepted (an OP_UNUSED request gives none). reset empties the queue and
// restores register defaults, no clearing pass. results cannot be stalled.
// ----------------------------------------------------------------------------
module congestion_paced_tx_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cpq_pkg::cpq_req_t request,
	output logic              done,
	output cpq_pkg::cpq_res_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import cpq_pkg::*;

	logic        ex_q;
	cpq_req_t    req_q;
	logic        done_q;
	cpq_res_t    res_q;
	logic [CNT_W-1:0] count_q;
	logic        server_busy_q;
	logic [15:0] hold_q;
	logic [15:0] window_q;
	logic [7:0]  mult_q;
	logic [6:0]  limit_q;

	logic [15:0] cell_id  [QUEUE_DEPTH];
	logic [15:0] cell_dur [QUEUE_DEPTH];

	op_t           op;
	logic          ev;
	logic          full;
	logic          push;
	logic          pop;
	logic [CNT_W-1:0] count_n;
	cpq_pace_ctl_t pace_ctl;
	logic          bn;
	logic [24:0]   svc;
	cpq_res_t      res_n;

	assign busy      = ex_q;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

	always_comb begin
		op   = op_t'(req_q.operation);
		ev   = ex_q && (op != OP_UNUSED);
		full = (CMP_W'(count_q) >= CMP_W'(limit_q)) ||
			(CNT_W'(QUEUE_DEPTH) <= count_q);
		push = ev && (op == OP_ARRIVE) && !full;
		pop  = ev && (op == OP_TICK) && (count_q != '0);
		pace_ctl.event_en = ev;
		pace_ctl.feedback = (op == OP_FEEDBACK);
		if (push) begin
			count_n = count_q + CNT_W'(1);
		end else if (pop) begin
			count_n = count_q - CNT_W'(1);
		end else begin
			count_n = count_q;
		end
		res_n.sent_id           = pop ? cell_id[0] : 16'd0;
		res_n.service_time      = pop ? svc : 25'd0;
		res_n.start_service     = pop || (push && !server_busy_q);
		res_n.bottleneck_active = bn;
		res_n.queue_count       = 7'(count_n);
		case (op)
			OP_ARRIVE:   res_n.status = push ? ST_QUEUED : ST_DROPPED;
			OP_FEEDBACK: res_n.status = ST_FEEDBACK;
			OP_TICK:     res_n.status = pop ? ST_SENT : ST_EMPTY;
			default:     res_n.status = ST_QUEUED;
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic [15:0] nxt_id;
			logic [15:0] nxt_dur;
			if (gi == QUEUE_DEPTH - 1) begin : g_tail
				assign nxt_id  = '0;
				assign nxt_dur = '0;
			end else begin : g_mid
				assign nxt_id  = cell_id[gi + 1];
				assign nxt_dur = cell_dur[gi + 1];
			end
			cpq_cell u_cell (
				.clk      (clk),
				.shift_en (pop),
				.load_en  (push && (count_q[IDX_W-1:0] == IDX_W'(gi))),
				.next_id  (nxt_id),
				.next_dur (nxt_dur),
				.load_id  (req_q.packet_id),
				.load_dur (req_q.packet_duration),
				.id       (cell_id[gi]),
				.dur      (cell_dur[gi])
			);
		end
	endgenerate

	cpq_pace u_pace (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (pace_ctl),
		.now             (req_q.now),
		.hold_time       (hold_q),
		.pen_win         (window_q),
		.base_multiplier (mult_q),
		.head_dur        (cell_dur[0]),
		.bottleneck      (bn),
		.service_time    (svc)
	);

	always_ff @(posedge clk) begin
		if (start && !ex_q) begin
			req_q <= request;
		end
		if (ex_q) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ex_q          <= 1'b0;
			done_q        <= 1'b0;
			count_q       <= '0;
			server_busy_q <= 1'b0;
			hold_q        <= HOLD_TIME_RST;
			window_q      <= PEN_WIN_RST;
			mult_q        <= BASE_MULT_RST;
			limit_q       <= BUFFER_LIMIT_RST;
		end else begin
			ex_q   <= start && !ex_q;
			done_q <= ev;
			if (ev) begin
				count_q <= count_n;
				if (pop || (push && !server_busy_q)) begin
					server_busy_q <= 1'b1;
				end else if ((op == OP_TICK) && !pop) begin
					server_busy_q <= 1'b0;
				end
			end
			if (cfg_valid) begin
				case (reg_idx_t'(cfg_index))
					REG_HOLD_TIME:    hold_q   <= cfg_data;
					REG_PEN_WIN:      window_q <= cfg_data;
					REG_BASE_MULT:    mult_q   <= cfg_data[7:0];
					REG_BUFFER_LIMIT: limit_q  <= cfg_data[6:0];
					default:          hold_q   <= hold_q;
				endcase
			end
		end
	end

endmodule

>>> tb/sv/congestion_paced_tx_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// congestion_paced_tx_queue_tb
// Self-checking bench for the paced transmit queue. Timestamped arrivals,
// congestion notices and service-end ticks go in through start/busy. A local
// model of the queue, the bottleneck timer and the penalty multiplier predicts
// every result, and each strobed result is checked field by field. Runs
// through several register settings and sender pacing modes.
// ----------------------------------------------------------------------------
module congestion_paced_tx_queue_tb;

	import cpq_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_TICKS = 4;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        busy;
	cpq_req_t    request   = '0;
	logic        done;
	cpq_res_t    result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_HOLD_TIME;
	logic [15:0] cfg_data  = '0;

	congestion_paced_tx_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register copies
	logic [15:0] hold_ticks   = HOLD_TIME_RST;
	logic [15:0] window_ticks = PEN_WIN_RST;
	logic [7:0]  pace_mult    = BASE_MULT_RST;
	logic [6:0]  drop_limit   = BUFFER_LIMIT_RST;

	// queue and pacing state
	logic [15:0] held_id  [QUEUE_DEPTH];
	logic [15:0] held_dur [QUEUE_DEPTH];
	logic [5:0]  head     = '0;
	logic [6:0]  held     = '0;
	logic        in_bn    = 1'b0;
	logic [31:0] bn_end   = '0;
	logic        pen_dbl  = 1'b0;
	logic        srv_busy = 1'b0;

	cpq_req_t event_backlog[$];
	cpq_res_t due_results[$];
	int       issued_cnt = 0;
	int       taken_cnt  = 0;
	int       idle_pct   = 0;
	int       errors     = 0;
	int       cycle_cnt  = 0;
	logic [31:0] timeline = '0;

	function automatic bit queue_event(input cpq_req_t rq, output cpq_res_t rs);
		longint      gap;
		logic [32:0] ends;
		logic [31:0] svc;
		logic [5:0]  slot;
		rs = '0;
		if (rq.operation == OP_UNUSED)
			return 1'b0;
		if (rq.operation == OP_FEEDBACK && !in_bn) begin
			gap  = longint'({32'd0, rq.now}) - longint'({32'd0, bn_end});
			ends = {1'b0, rq.now} + {17'd0, hold_ticks};
			in_bn = 1'b1;
			if (gap < longint'({48'd0, window_ticks}))
				pen_dbl = 1'b1;
			bn_end = ends[32] ? 32'hFFFF_FFFF : ends[31:0];
		end
		if (in_bn && rq.now >= bn_end) begin
			in_bn   = 1'b0;
			pen_dbl = 1'b0;
		end
		if (rq.operation == OP_FEEDBACK) begin
			rs.status = ST_FEEDBACK;
		end else if (rq.operation == OP_TICK) begin
			if (held == 0) begin
				rs.status = ST_EMPTY;
				srv_busy  = 1'b0;
			end else begin
				svc = {16'd0, held_dur[head]};
				if (in_bn)
					svc = svc * {24'd0, pace_mult} * (pen_dbl ? 32'd2 : 32'd1);
				rs.sent_id       = held_id[head];
				rs.service_time  = svc[24:0];
				rs.start_service = 1'b1;
				rs.status        = ST_SENT;
				head     = head + 6'd1;
				held     = held - 7'd1;
				srv_busy = 1'b1;
			end
		end else begin
			if (held >= drop_limit || held >= QUEUE_DEPTH) begin
				rs.status = ST_DROPPED;
			end else begin
				slot = head + held[5:0];
				held_id[slot]  = rq.packet_id;
				held_dur[slot] = rq.packet_duration;
				held = held + 7'd1;
				rs.status = ST_QUEUED;
				if (!srv_busy) begin
					srv_busy = 1'b1;
					rs.start_service = 1'b1;
				end
			end
		end
		rs.bottleneck_active = in_bn;
		rs.queue_count       = held;
		return 1'b1;
	endfunction

	// driver
	always @(negedge clk) begin
		if (!(start && taken_cnt != issued_cnt)) begin
			if (event_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				request <= event_backlog.pop_front();
				start   <= 1'b1;
				issued_cnt++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin : mon
		cpq_res_t want;
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("RESULT: ERROR");
			$finish;
		end
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: got %p", result);
			end else begin
				want = due_results.pop_front();
				if (result.status !== want.status || result.sent_id !== want.sent_id ||
				    result.service_time !== want.service_time ||
				    result.start_service !== want.start_service ||
				    result.bottleneck_active !== want.bottleneck_active ||
				    result.queue_count !== want.queue_count) begin
					errors++;
					if (errors <= 10)
						$display("mismatch at %0t: expected %p, got %p", $realtime, want, result);
				end
			end
		end
		if (arst_n && start && !busy) begin
			taken_cnt++;
			if (queue_event(request, want))
				due_results.push_back(want);
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_HOLD_TIME:    hold_ticks   = val;
			REG_PEN_WIN:      window_ticks = val;
			REG_BASE_MULT:    pace_mult    = val[7:0];
			REG_BUFFER_LIMIT: drop_limit   = val[6:0];
			default:          ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_setting(input int h, input int p, input int m, input int b);
		write_reg(REG_HOLD_TIME, 16'(h));
		write_reg(REG_PEN_WIN, 16'(p));
		write_reg(REG_BASE_MULT, 16'(m));
		write_reg(REG_BUFFER_LIMIT, 16'(b));
	endtask

	task automatic push_evt(input op_t op, input logic [31:0] t,
	                        input logic [15:0] id, input logic [15:0] dur);
		cpq_req_t rq;
		rq.operation       = op;
		rq.now             = t;
		rq.packet_id       = id;
		rq.packet_duration = dur;
		event_backlog.push_back(rq);
	endtask

	task automatic push_random(input int count, input int arrive_pct);
		int   made;
		int   pick;
		int   step;
		op_t  op;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(0, 99);
			if (pick < arrive_pct)
				op = OP_ARRIVE;
			else if (pick < arrive_pct + 12)
				op = OP_FEEDBACK;
			else if (pick < 98)
				op = OP_TICK;
			else
				op = OP_UNUSED;
			step = $urandom_range(0, 99);
			if (step < 2)
				timeline = $urandom;
			else if (step < 5)
				timeline = timeline - $urandom_range(0, 20);
			else if (step < 12)
				timeline = timeline + $urandom_range(0, 2 * hold_ticks + window_ticks + 2);
			else
				timeline = timeline + $urandom_range(0, 4);
			push_evt(op, timeline, 16'($urandom), 16'($urandom));
			if (op != OP_UNUSED)
				made++;
		end
	endtask

	task automatic drain;
		while (event_backlog.size() != 0 || taken_cnt != issued_cnt || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, default registers
		push_evt(OP_TICK,     32'd0,  16'h0000, 16'h0000);
		push_evt(OP_ARRIVE,   32'd1,  16'hFFFF, 16'hFFFF);
		push_evt(OP_ARRIVE,   32'd2,  16'h0000, 16'h0000);
		push_evt(OP_TICK,     32'd3,  16'h5A5A, 16'hA5A5);
		push_evt(OP_FEEDBACK, 32'd10, 16'h0000, 16'h0000);
		push_evt(OP_ARRIVE,   32'd11, 16'h1234, 16'h8000);
		push_evt(OP_FEEDBACK, 32'd12, 16'h0000, 16'h0000);
		push_evt(OP_TICK,     32'd12, 16'h0000, 16'h0000);
		push_evt(OP_TICK,     32'd13, 16'h0000, 16'h0000);
		push_evt(OP_ARRIVE,   32'd15, 16'h00FF, 16'h0001);
		push_evt(OP_FEEDBACK, 32'd20, 16'h0000, 16'h0000);
		push_evt(OP_ARRIVE,   32'd21, 16'hAAAA, 16'hFFFF);
		push_evt(OP_TICK,     32'd21, 16'h0000, 16'h0000);
		push_evt(OP_TICK,     32'd22, 16'h0000, 16'h0000);
		push_evt(OP_UNUSED,   32'd23, 16'hFFFF, 16'hFFFF);
		push_evt(OP_TICK,     32'd30, 16'h0000, 16'h0000);
		push_evt(OP_TICK,     32'd31, 16'h0000, 16'h0000);
		// window end saturates near the top of the time range
		push_evt(OP_FEEDBACK, 32'hFFFF_FFFE, 16'h0000, 16'h0000);
		push_evt(OP_ARRIVE,   32'hFFFF_FFFE, 16'h7777, 16'h0003);
		push_evt(OP_TICK,     32'hFFFF_FFFF, 16'h0000, 16'h0000);
		// time earlier than the window end counts as within the penalty window
		push_evt(OP_FEEDBACK, 32'd100, 16'h0000, 16'h0000);
		push_evt(OP_ARRIVE,   32'd101, 16'h0101, 16'h0010);
		push_evt(OP_TICK,     32'd102, 16'h0000, 16'h0000);
		push_evt(OP_TICK,     32'd106, 16'h0000, 16'h0000);
		drain();

		timeline = 32'd200;
		idle_pct = 0;
		push_random(130, 45);
		drain();

		apply_setting(0, 0, 1, 0);
		idle_pct = 77;
		push_random(150, 45);
		drain();

		apply_setting(65535, 65535, 255, 64);
		idle_pct = 19;
		push_random(150, 62);
		drain();

		apply_setting(3, 40, 7, 5);
		idle_pct = 0;
		push_random(150, 50);
		drain();

		apply_setting($urandom_range(0, 64), $urandom_range(0, 100),
		              $urandom_range(1, 255), $urandom_range(1, 64));
		idle_pct = 77;
		push_random(150, 48);
		drain();

		apply_setting($urandom_range(0, 64), $urandom_range(0, 100),
		              $urandom_range(1, 255), $urandom_range(1, 64));
		idle_pct = 19;
		push_random(150, 65);
		drain();

		apply_setting(20, 65535, 255, 64);
		idle_pct = 0;
		push_random(150, 40);
		drain();

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
